[design/sgcw_pkg.sv]
// ----------------------------------------------------------------------------
// sgcw_pkg
// Shared types and constants for the segment grid cell walk.
// ----------------------------------------------------------------------------
`default_nettype none

package sgcw_pkg;

  localparam int unsigned MAX_DIVISIONS = 32;
  localparam int unsigned WALK_LIMIT    = 2 * MAX_DIVISIONS - 1;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CELL_W  = $clog2(MAX_DIVISIONS);
  localparam int unsigned DIV_W   = CELL_W + 1;
  localparam int unsigned CNT_W   = $clog2(WALK_LIMIT + 1);
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned ACC_W   = PROD_W + CNT_W;
  localparam int unsigned BIT_W   = $clog2(COORD_W);

  localparam logic [COORD_W-1:0] CELL_SIZE_RESET = 32'h0001_0000;
  localparam logic [DIV_W-1:0]   GRID_DIV_RESET  = DIV_W'(MAX_DIVISIONS);

  typedef enum logic [0:0] {
    CFG_CELL_SIZE = 1'b0,
    CFG_GRID_DIV  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_XS = 2'd0,
    OP_YS = 2'd1,
    OP_XE = 2'd2,
    OP_YE = 2'd3
  } div_op_t;

  typedef enum logic [1:0] {
    MUL_TX = 2'd0,
    MUL_TY = 2'd1,
    MUL_SX = 2'd2,
    MUL_SY = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_MUL,
    ST_WALK
  } state_t;

  function automatic logic [CELL_W-1:0] wrap_step(
    input logic [CELL_W-1:0] c,
    input logic              up,
    input logic [DIV_W-1:0]  div
  );
    logic [DIV_W-1:0] inc;
    inc = {1'b0, c} + DIV_W'(1);
    if (up) begin
      wrap_step = (inc >= div) ? '0 : inc[CELL_W-1:0];
    end else begin
      wrap_step = (c == '0) ? CELL_W'(div - DIV_W'(1)) : c - CELL_W'(1);
    end
  endfunction

endpackage

`default_nettype wire

[design/segment_grid_cell_walk.sv]
// ----------------------------------------------------------------------------
// segment_grid_cell_walk
// 2D grid traversal: emits the cells a Q16.16 segment passes through, up to 63 a segment.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  cfg     | cfg_write, cfg_index, cfg_data           | in, write only
//  in      | in_valid/in_ready, x_start..y_end        | in, one segment a beat
//  out     | out_valid/out_ready, cell_x/y, last_cell | out, one cell a beat
//
//  Per segment: a bit-serial divide of each coordinate, a setup step, the four
//  products on the shared multiplier, then one cell a cycle unless stalled (1 to 63 cells).
//  The bit-serial divider sets the front end; the walk runs one step a cycle while not stalled.
//  Reset restores cell_size to 1.0 and grid_divisions to 32.
//  A stalled output holds the walk; the next segment is taken once the
//  final cell is in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_grid_cell_walk (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [sgcw_pkg::COORD_W-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sgcw_pkg::COORD_W-1:0]     x_start,
  input  wire logic [sgcw_pkg::COORD_W-1:0]     y_start,
  input  wire logic [sgcw_pkg::COORD_W-1:0]     x_end,
  input  wire logic [sgcw_pkg::COORD_W-1:0]     y_end,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sgcw_pkg::CELL_W-1:0]           cell_x,
  output logic [sgcw_pkg::CELL_W-1:0]           cell_y,
  output logic                                  last_cell
);

  localparam int unsigned CW = sgcw_pkg::COORD_W;
  localparam int unsigned EW = sgcw_pkg::CELL_W;
  localparam int unsigned DW = sgcw_pkg::DIV_W;

  sgcw_pkg::state_t state, state_next;

  logic [CW-1:0] cell_size;
  logic [DW-1:0] grid_div;
  logic [CW-1:0] size_eff;
  logic [DW-1:0] div_eff;

  logic [CW-1:0] xs, ys, xe, ye;
  logic [1:0]    op_idx;
  logic [sgcw_pkg::BIT_W-1:0] bit_idx;
  logic [CW-1:0] rem;
  logic [EW-1:0] qmod;
  logic [CW-1:0] rem_x, rem_y;
  logic [EW-1:0] cx, cy, ex, ey;
  logic          xup, yup;
  logic [CW-1:0] adx, ady, tx0, ty0;
  logic [1:0]    mul_idx;
  logic [sgcw_pkg::ACC_W-1:0]  px, py;
  logic [sgcw_pkg::PROD_W-1:0] sx, sy;
  logic [sgcw_pkg::CNT_W-1:0]  n;

  logic [CW-1:0] dvd;
  logic [CW:0]   r_sh;
  logic          r_ge;
  logic [CW-1:0] r_new;
  logic [DW-1:0] q_sh;
  logic [EW-1:0] q_new;

  logic [CW-1:0] mul_a, mul_b;
  logic [sgcw_pkg::PROD_W-1:0] mul_p;

  logic at_end, fin, step_x, emit;

  // effective configuration
  always_comb begin
    size_eff = (cell_size == '0) ? CW'(1) : cell_size;
    if (grid_div == '0) begin
      div_eff = DW'(1);
    end else if (grid_div > DW'(sgcw_pkg::MAX_DIVISIONS)) begin
      div_eff = DW'(sgcw_pkg::MAX_DIVISIONS);
    end else begin
      div_eff = grid_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= sgcw_pkg::CELL_SIZE_RESET;
      grid_div  <= sgcw_pkg::GRID_DIV_RESET;
    end else if (cfg_write) begin
      unique case (sgcw_pkg::cfg_index_t'(cfg_index))
        sgcw_pkg::CFG_CELL_SIZE: cell_size <= cfg_data;
        sgcw_pkg::CFG_GRID_DIV:  grid_div  <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // bit-serial restoring divider, quotient kept modulo the division count
  always_comb begin
    unique case (sgcw_pkg::div_op_t'(op_idx))
      sgcw_pkg::OP_XS: dvd = xs;
      sgcw_pkg::OP_YS: dvd = ys;
      sgcw_pkg::OP_XE: dvd = xe;
      sgcw_pkg::OP_YE: dvd = ye;
      default:         dvd = xs;
    endcase
    r_sh  = {rem, dvd[bit_idx]};
    r_ge  = r_sh >= {1'b0, size_eff};
    r_new = r_ge ? CW'(r_sh - {1'b0, size_eff}) : r_sh[CW-1:0];
    q_sh  = {qmod, r_ge};
    q_new = (q_sh >= div_eff) ? EW'(q_sh - div_eff) : q_sh[EW-1:0];
  end

  // shared multiplier
  always_comb begin
    unique case (sgcw_pkg::mul_op_t'(mul_idx))
      sgcw_pkg::MUL_TX: begin mul_a = tx0;      mul_b = ady; end
      sgcw_pkg::MUL_TY: begin mul_a = ty0;      mul_b = adx; end
      sgcw_pkg::MUL_SX: begin mul_a = size_eff; mul_b = ady; end
      sgcw_pkg::MUL_SY: begin mul_a = size_eff; mul_b = adx; end
      default:          begin mul_a = tx0;      mul_b = ady; end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    at_end = (cx == ex) && (cy == ey);
    fin    = at_end || (n == sgcw_pkg::CNT_W'(sgcw_pkg::WALK_LIMIT - 1));
    step_x = (adx != '0) && ((ady == '0) || (px < py));
    emit   = (state == sgcw_pkg::ST_WALK) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgcw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      sgcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = sgcw_pkg::ST_DIV;
        end
      end
      sgcw_pkg::ST_DIV: begin
        if (bit_idx == '0 && op_idx == 2'(sgcw_pkg::OP_YE)) begin
          state_next = sgcw_pkg::ST_SETUP;
        end
      end
      sgcw_pkg::ST_SETUP: state_next = sgcw_pkg::ST_MUL;
      sgcw_pkg::ST_MUL: begin
        if (mul_idx == 2'(sgcw_pkg::MUL_SY)) begin
          state_next = sgcw_pkg::ST_WALK;
        end
      end
      sgcw_pkg::ST_WALK: begin
        if (emit && fin) begin
          state_next = sgcw_pkg::ST_IDLE;
        end
      end
      default: state_next = sgcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_x    <= cx;
      cell_y    <= cy;
      last_cell <= fin;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sgcw_pkg::ST_IDLE: begin
        xs      <= x_start;
        ys      <= y_start;
        xe      <= x_end;
        ye      <= y_end;
        op_idx  <= '0;
        bit_idx <= sgcw_pkg::BIT_W'(CW - 1);
        rem     <= '0;
        qmod    <= '0;
      end
      sgcw_pkg::ST_DIV: begin
        if (bit_idx == '0) begin
          unique case (sgcw_pkg::div_op_t'(op_idx))
            sgcw_pkg::OP_XS: begin cx <= q_new; rem_x <= r_new; end
            sgcw_pkg::OP_YS: begin cy <= q_new; rem_y <= r_new; end
            sgcw_pkg::OP_XE: ex <= q_new;
            sgcw_pkg::OP_YE: ey <= q_new;
            default: ;
          endcase
          rem     <= '0;
          qmod    <= '0;
          op_idx  <= op_idx + 2'd1;
          bit_idx <= sgcw_pkg::BIT_W'(CW - 1);
        end else begin
          rem     <= r_new;
          qmod    <= q_new;
          bit_idx <= bit_idx - sgcw_pkg::BIT_W'(1);
        end
      end
      sgcw_pkg::ST_SETUP: begin
        xup     <= xe >= xs;
        yup     <= ye >= ys;
        adx     <= (xe >= xs) ? xe - xs : xs - xe;
        ady     <= (ye >= ys) ? ye - ys : ys - ye;
        tx0     <= (xe >= xs) ? size_eff - rem_x : rem_x;
        ty0     <= (ye >= ys) ? size_eff - rem_y : rem_y;
        mul_idx <= '0;
        n       <= '0;
      end
      sgcw_pkg::ST_MUL: begin
        unique case (sgcw_pkg::mul_op_t'(mul_idx))
          sgcw_pkg::MUL_TX: px <= sgcw_pkg::ACC_W'(mul_p);
          sgcw_pkg::MUL_TY: py <= sgcw_pkg::ACC_W'(mul_p);
          sgcw_pkg::MUL_SX: sx <= mul_p;
          sgcw_pkg::MUL_SY: sy <= mul_p;
          default: ;
        endcase
        mul_idx <= mul_idx + 2'd1;
      end
      sgcw_pkg::ST_WALK: begin
        if (emit && !fin) begin
          n <= n + sgcw_pkg::CNT_W'(1);
          if (step_x) begin
            px <= px + sgcw_pkg::ACC_W'(sx);
            cx <= sgcw_pkg::wrap_step(cx, xup, div_eff);
          end else begin
            py <= py + sgcw_pkg::ACC_W'(sy);
            cy <= sgcw_pkg::wrap_step(cy, yup, div_eff);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/sgcw_checker.sv]
// ----------------------------------------------------------------------------
// sgcw_checker
// Port-level checks on the segment grid cell walk, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgcw_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [sgcw_pkg::CELL_W-1:0]  cell_x,
  input wire logic [sgcw_pkg::CELL_W-1:0]  cell_y,
  input wire logic                         last_cell
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_x) && $stable(cell_y)
      && $stable(last_cell))
    else $error("stalled output beat changed");

  // drop ready once a segment is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accepting a segment");

  // no new segment while a walk is still unfinished
  a_no_accept_mid_walk: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_cell |-> !in_ready)
    else $error("ready in the middle of a walk");

  // a non-final beat is always followed by more of the same walk
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_cell |=> out_valid)
    else $error("walk ended without a final cell");

endmodule

bind segment_grid_cell_walk sgcw_checker u_sgcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cell_x    (cell_x),
  .cell_y    (cell_y),
  .last_cell (last_cell)
);

`default_nettype wire

[sim/sgcw_walk_checker.sv]
// ----------------------------------------------------------------------------
// sgcw_walk_checker
// Watches the configuration port and both handshake channels of the segment
// grid cell walk. For every segment beat it traces the grid cells the segment
// crosses, using its own copy of the cell size and the division count. Each
// cell beat is then checked field by field against the oldest traced cell.
// ----------------------------------------------------------------------------
module sgcw_walk_checker
  import sgcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [COORD_W-1:0] cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [COORD_W-1:0] x_start,
  input  wire logic [COORD_W-1:0] y_start,
  input  wire logic [COORD_W-1:0] x_end,
  input  wire logic [COORD_W-1:0] y_end,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [CELL_W-1:0]  cell_x,
  input  wire logic [CELL_W-1:0]  cell_y,
  input  wire logic               last_cell,
  output int unsigned             errors,
  output int unsigned             pending,
  output int unsigned             segments,
  output int unsigned             cells,
  output int unsigned             capped
);

  typedef struct packed {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic              last;
  } grid_cell_t;

  grid_cell_t         cells_due[$];
  logic [COORD_W-1:0] cell_size_q;
  logic [DIV_W-1:0]   grid_div_q;
  int unsigned        err_n  = 0;
  int unsigned        seg_n  = 0;
  int unsigned        cell_n = 0;
  int unsigned        cap_n  = 0;

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    err_n++;
    if (err_n <= 40) begin
      $display("mismatch at cell beat %0d: %s is %0d, expected %0d", cell_n, field, got,
               want);
    end
  endtask

  function automatic int unsigned next_index(input int unsigned c, input bit up,
                                             input int unsigned dv);
    if (up) begin
      return (c + 1 >= dv) ? 0 : c + 1;
    end
    return (c == 0) ? dv - 1 : c - 1;
  endfunction

  // Trace the cells crossed by one segment and queue them in walk order.
  function automatic void trace_cells(input logic [COORD_W-1:0] xs,
                                      input logic [COORD_W-1:0] ys,
                                      input logic [COORD_W-1:0] xe,
                                      input logic [COORD_W-1:0] ye);
    longint unsigned size;
    longint unsigned adx;
    longint unsigned ady;
    longint unsigned tx;
    longint unsigned ty;
    logic [127:0]    cross_x;
    logic [127:0]    cross_y;
    int unsigned     dv;
    int unsigned     cx;
    int unsigned     cy;
    int unsigned     ex;
    int unsigned     ey;
    int unsigned     n;
    bit              xup;
    bit              yup;
    bit              done;
    grid_cell_t      c;
    size = (cell_size_q == '0) ? 64'd1 : {32'b0, cell_size_q};
    dv   = 32'(grid_div_q);
    if (dv == 0) dv = 1;
    if (dv > MAX_DIVISIONS) dv = MAX_DIVISIONS;
    xup  = (xe >= xs);
    yup  = (ye >= ys);
    adx  = xup ? {32'b0, xe} - {32'b0, xs} : {32'b0, xs} - {32'b0, xe};
    ady  = yup ? {32'b0, ye} - {32'b0, ys} : {32'b0, ys} - {32'b0, ye};
    cx   = 32'(({32'b0, xs} / size) % dv);
    cy   = 32'(({32'b0, ys} / size) % dv);
    ex   = 32'(({32'b0, xe} / size) % dv);
    ey   = 32'(({32'b0, ye} / size) % dv);
    tx   = xup ? size - ({32'b0, xs} % size) : {32'b0, xs} % size;
    ty   = yup ? size - ({32'b0, ys} % size) : {32'b0, ys} % size;
    n    = 0;
    done = 0;
    while (!done) begin
      c.x    = cx[CELL_W-1:0];
      c.y    = cy[CELL_W-1:0];
      c.last = 1'b0;
      n++;
      if ((cx == ex && cy == ey) || n >= WALK_LIMIT) begin
        c.last = 1'b1;
        done   = 1;
        if (n >= WALK_LIMIT) cap_n++;
      end
      cells_due.push_back(c);
      if (!done) begin
        // compare tx/adx against ty/ady without division; ties go to y
        cross_x = 128'(tx) * 128'(ady);
        cross_y = 128'(ty) * 128'(adx);
        if (adx != 0 && (ady == 0 || cross_x < cross_y)) begin
          tx = tx + size;
          cx = next_index(cx, xup, dv);
        end else begin
          ty = ty + size;
          cy = next_index(cy, yup, dv);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    grid_cell_t want;
    if (rst) begin
      cell_size_q = CELL_SIZE_RESET;
      grid_div_q  = GRID_DIV_RESET;
      cells_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        cell_n++;
        if (cells_due.size() == 0) begin
          report_mismatch("unexpected cell, x", cell_x, 0);
        end else begin
          want = cells_due.pop_front();
          if (cell_x !== want.x) report_mismatch("cell_x", cell_x, want.x);
          if (cell_y !== want.y) report_mismatch("cell_y", cell_y, want.y);
          if (last_cell !== want.last) report_mismatch("last_cell", last_cell, want.last);
        end
      end
      if (in_valid && in_ready) begin
        seg_n++;
        trace_cells(x_start, y_start, x_end, y_end);
      end
      if (cfg_write) begin
        if (cfg_index == CFG_CELL_SIZE) begin
          cell_size_q = cfg_data;
        end else if (cfg_index == CFG_GRID_DIV) begin
          grid_div_q = cfg_data[DIV_W-1:0];
        end
      end
    end
    errors   <= err_n;
    pending  <= cells_due.size();
    segments <= seg_n;
    cells    <= cell_n;
    capped   <= cap_n;
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives segments into the segment grid cell walk under several grid
// settings: a directed set of corner cases at reset settings, then mostly
// short random segments with random content. The sender works in bursts and
// the receiver stalls on patterns of its own; the checker beside the block
// traces the expected cells and counts failures.
// ----------------------------------------------------------------------------
module testbench;
  import sgcw_pkg::*;

  localparam int unsigned DIRECTED_N     = 14;
  localparam int unsigned PHASE_N        = 9;
  localparam int unsigned RAND_PER_PHASE = 55;
  localparam int unsigned HOLD_PHASE     = 3;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned TAIL_CYCLES    = 300;
  // covers the divider front end, the long hold and the widest sender gap,
  // taken several times over
  localparam int unsigned IDLE_LIMIT     = 5000;

  typedef enum int unsigned {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  cfg_index_t         cfg_index = CFG_CELL_SIZE;
  logic [COORD_W-1:0] cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] x_start   = '0;
  logic [COORD_W-1:0] y_start   = '0;
  logic [COORD_W-1:0] x_end     = '0;
  logic [COORD_W-1:0] y_end     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CELL_W-1:0]  cell_x;
  logic [CELL_W-1:0]  cell_y;
  logic               last_cell;
  logic               hold_now  = 1'b0;

  int unsigned        errors;
  int unsigned        pending;
  int unsigned        segments;
  int unsigned        cells;
  int unsigned        capped;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left  = 1;
  longint unsigned    cur_size    = 64'h1_0000;

  segment_grid_cell_walk u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .last_cell (last_cell)
  );

  sgcw_walk_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .last_cell (last_cell),
    .errors    (errors),
    .pending   (pending),
    .segments  (segments),
    .cells     (cells),
    .capped    (capped)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d cells outstanding", IDLE_LIMIT,
               pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return '1;
    return v[COORD_W-1:0];
  endfunction

  // Move a coordinate by up to five cells plus a random fraction, either way.
  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base,
                                               input longint unsigned cs);
    longint d;
    d = longint'($urandom_range(0, 5)) * longint'(cs)
        + longint'({32'b0, $urandom} % cs);
    if ($urandom_range(0, 1) == 1) d = -d;
    return clamp_coord(longint'({32'b0, base}) + d);
  endfunction

  function automatic void pick_segment(input longint unsigned cs,
                                       output logic [COORD_W-1:0] xs,
                                       output logic [COORD_W-1:0] ys,
                                       output logic [COORD_W-1:0] xe,
                                       output logic [COORD_W-1:0] ye);
    int unsigned kind;
    longint      span;
    kind = $urandom_range(0, 9);
    xs   = $urandom;
    ys   = $urandom;
    xe   = nudge(xs, cs);
    ye   = nudge(ys, cs);
    case (kind)
      0: begin
        xe = $urandom;
        ye = $urandom;
      end
      1: begin
        xe = xs;
        ye = ys;
      end
      2: ye = ys;
      3: xe = xs;
      4: begin
        // corner to corner on a 45 degree line: crossings tie
        xs   = clamp_coord(longint'($urandom_range(0, 40)) * longint'(cs));
        ys   = clamp_coord(longint'($urandom_range(0, 40)) * longint'(cs));
        span = longint'($urandom_range(1, 6)) * longint'(cs);
        xe   = clamp_coord(longint'({32'b0, xs}) + ($urandom_range(0, 1) ? span : -span));
        ye   = clamp_coord(longint'({32'b0, ys}) + ($urandom_range(0, 1) ? span : -span));
      end
      default: ;
    endcase
  endfunction

  function automatic void directed_segment(input int unsigned i,
                                           output logic [COORD_W-1:0] xs,
                                           output logic [COORD_W-1:0] ys,
                                           output logic [COORD_W-1:0] xe,
                                           output logic [COORD_W-1:0] ye);
    case (i)
      0:  {xs, ys, xe, ye} = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      1:  {xs, ys, xe, ye} = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      2:  {xs, ys, xe, ye} = {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      3:  {xs, ys, xe, ye} = {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      4:  {xs, ys, xe, ye} = {32'h0001_8000, 32'h0002_0000, 32'h0005_4000, 32'h0002_0000};
      5:  {xs, ys, xe, ye} = {32'h0003_0000, 32'h0006_8000, 32'h0003_0000, 32'h0001_0000};
      6:  {xs, ys, xe, ye} = {32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0004_0000};
      7:  {xs, ys, xe, ye} = {32'h0004_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000};
      8:  {xs, ys, xe, ye} = {32'h001F_8000, 32'h0003_4000, 32'h0021_8000, 32'h0003_4000};
      9:  {xs, ys, xe, ye} = {32'h0020_8000, 32'h0020_4000, 32'h001E_8000, 32'h001F_2000};
      10: {xs, ys, xe, ye} = {32'h0000_1234, 32'h0000_5678, 32'h0007_9ABC, 32'h0002_DEF0};
      11: {xs, ys, xe, ye} = {32'h0009_C000, 32'h0007_4000, 32'h0002_2000, 32'h0003_E000};
      12: {xs, ys, xe, ye} = {32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA};
      default: {xs, ys, xe, ye} = {32'h0000_FFFF, 32'h0000_0000, 32'h0001_0000,
                                   32'h0000_0000};
    endcase
  endfunction

  function automatic void phase_grid(input int unsigned p, output logic [COORD_W-1:0] cs,
                                     output logic [5:0] dv);
    case (p)
      0:       {cs, dv} = {32'h0001_0000, 6'd32};
      1:       {cs, dv} = {32'h0000_0001, 6'd1};
      2:       {cs, dv} = {32'hFFFF_FFFF, 6'd32};
      3:       {cs, dv} = {32'h0000_4000, 6'd8};
      4:       {cs, dv} = {32'h0000_0000, 6'd5};
      5:       {cs, dv} = {32'h0002_8000, 6'd0};
      6:       {cs, dv} = {32'h0000_0100, 6'd40};
      7:       {cs, dv} = {32'h0000_C000, 6'd63};
      default: {cs, dv} = {32'h0003_0000, 6'd17};
    endcase
  endfunction

  task automatic offer_segment(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                               input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye);
    int unsigned gap;
    in_valid <= 1'b1;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 5) gap = $urandom_range(1, 5);
      else if ($urandom_range(0, 9) < 6) gap = $urandom_range(6, 40);
      else gap = $urandom_range(41, 200);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_grid(input logic [COORD_W-1:0] cs, input logic [5:0] dv);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CELL_SIZE;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_index <= CFG_GRID_DIV;
    cfg_data  <= {{(COORD_W-6){1'b0}}, dv};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned tick;
    bit          held;
    held = 0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 250);
      repeat (span) begin
        if (hold_now && !held) begin
          held = 1;
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        tick++;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
          default:   out_ready <= (tick % 4 != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] cs;
    logic [5:0]         dv;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 40);
    for (int unsigned i = 0; i < DIRECTED_N; i++) begin
      directed_segment(i, xs, ys, xe, ye);
      offer_segment(xs, ys, xe, ye);
    end
    for (int unsigned p = 0; p < PHASE_N; p++) begin
      // drain before touching the registers
      wait_drained();
      phase_grid(p, cs, dv);
      set_grid(cs, dv);
      cur_size = (cs == '0) ? 64'd1 : {32'b0, cs};
      for (int unsigned k = 0; k < RAND_PER_PHASE; k++) begin
        if (p == HOLD_PHASE && k == 10) hold_now <= 1'b1;
        pick_segment(cur_size, xs, ys, xe, ye);
        offer_segment(xs, ys, xe, ye);
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("walked %0d segments into %0d cells over %0d grid settings,", segments, cells,
             PHASE_N);
    $display("%0d walks cut short at the cell limit, %0d mismatches", capped, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sgcw_pkg.sv
design/segment_grid_cell_walk.sv
design/sgcw_checker.sv
sim/sgcw_walk_checker.sv
sim/testbench.sv
